// ===== hdl/fwtbh_pkg.sv =====
package fwtbh_pkg;

    // field widths
    localparam int DRIVE_W = 17;
    localparam int RPM_W   = 13;
    localparam int ERR_W   = 14;
    localparam int TGT_W   = 10;
    localparam int POS_W   = 32;
    localparam int CFG_W   = 16;

    // serial multiplier: unsigned a times left-aligned b, two bits of b per cycle
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CNT_W   = 4;

    // restoring divider: one quotient bit per cycle
    localparam int DEN_W   = 48;
    localparam int QUOT_W  = 14;
    localparam int DSH_W   = DEN_W + QUOT_W - 1;

    localparam logic [CNT_W-1:0] DIGITS_FULL = CNT_W'(MUL_B_W / 2);
    localparam logic [CNT_W-1:0] DIGITS_HALF = CNT_W'(MUL_B_W / 4);

    localparam logic [DRIVE_W-1:0] DRIVE_ONE  = 17'd65536;
    localparam logic [29:0]        SUM_ONE    = 30'd16777216;
    localparam logic [15:0]        RPM_SCALE  = 16'd60000;
    localparam logic [RPM_W-1:0]   RPM_MAX    = 13'h0FFF;
    localparam logic [RPM_W-1:0]   RPM_MIN    = 13'h1000;

    localparam logic FUNC_SAMPLE     = 1'b0;
    localparam logic FUNC_SET_TARGET = 1'b1;

    typedef enum logic [1:0] {
        CFG_COUNTS_PER_REV = 2'd0,
        CFG_LOOP_GAIN      = 2'd1,
        CFG_MAX_POWER      = 2'd2,
        CFG_FULL_SCALE_MV  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                   start;
        logic [MUL_A_W-1:0]     a;
        logic [MUL_B_W-1:0]     b;
        logic [CNT_W-1:0]       digits;
    } mul_req_t;

    typedef struct packed {
        logic                   busy;
        logic [PROD_W-1:0]      prod;
    } mul_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [PROD_W-1:0]      num;
        logic [DEN_W-1:0]       den;
    } div_req_t;

    typedef struct packed {
        logic                   busy;
        logic [QUOT_W-1:0]      quot;
    } div_rsp_t;

endpackage

// ===== hdl/fwtbh_if.sv =====
interface fwtbh_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic signed [31:0] encoder_position;
    logic [31:0] timestamp_ms;
    logic [9:0]  target_rpm;
    logic [16:0] open_loop_drive;

    modport source (
        output valid, func, encoder_position, timestamp_ms, target_rpm, open_loop_drive,
        input  ready
    );
    modport sink (
        input  valid, func, encoder_position, timestamp_ms, target_rpm, open_loop_drive,
        output ready
    );
endinterface

interface fwtbh_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  motor_power;
    logic [13:0] voltage_mv;
    logic signed [12:0] measured_rpm;
    logic [16:0] drive_level;
    logic        crossed;

    modport source (
        output valid, motor_power, voltage_mv, measured_rpm, drive_level, crossed,
        input  ready
    );
    modport sink (
        input  valid, motor_power, voltage_mv, measured_rpm, drive_level, crossed,
        output ready
    );
endinterface

// ===== hdl/fwtbh_mul.sv =====
module fwtbh_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  fwtbh_pkg::mul_req_t req,
    output fwtbh_pkg::mul_rsp_t rsp
);

    logic [fwtbh_pkg::MUL_A_W-1:0] a_reg;
    logic [fwtbh_pkg::MUL_B_W-1:0] b_reg;
    logic [fwtbh_pkg::PROD_W-1:0]  acc_reg;
    logic [fwtbh_pkg::PROD_W-1:0]  acc_next;
    logic [fwtbh_pkg::CNT_W-1:0]   cnt_reg;
    logic [fwtbh_pkg::MUL_A_W+1:0] pp;

    // radix-4 digit from the top of b
    always_comb
    begin
        pp = (b_reg[fwtbh_pkg::MUL_B_W-1] ? {1'b0, a_reg, 1'b0} : '0)
           + (b_reg[fwtbh_pkg::MUL_B_W-2] ? {2'b00, a_reg} : '0);
        acc_next = {acc_reg[fwtbh_pkg::PROD_W-3:0], 2'b00} + fwtbh_pkg::PROD_W'(pp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
            cnt_reg <= req.digits;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[fwtbh_pkg::MUL_B_W-3:0], 2'b00};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.prod = acc_reg;

endmodule

// ===== hdl/fwtbh_div.sv =====
module fwtbh_div (
    input  logic                clk,
    input  logic                rst_n,
    input  fwtbh_pkg::div_req_t req,
    output fwtbh_pkg::div_rsp_t rsp
);

    localparam logic [fwtbh_pkg::CNT_W-1:0] STEPS = fwtbh_pkg::CNT_W'(fwtbh_pkg::QUOT_W);

    logic [fwtbh_pkg::PROD_W-1:0] r_reg;
    logic [fwtbh_pkg::DSH_W-1:0]  dsh_reg;
    logic [fwtbh_pkg::QUOT_W-1:0] q_reg;
    logic [fwtbh_pkg::CNT_W-1:0]  cnt_reg;
    logic                         ge;

    assign ge = ({{(fwtbh_pkg::DSH_W-fwtbh_pkg::PROD_W){1'b0}}, r_reg} >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= '0;
            dsh_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            r_reg   <= req.num;
            dsh_reg <= {req.den, {(fwtbh_pkg::QUOT_W-1){1'b0}}};
            q_reg   <= '0;
            cnt_reg <= STEPS;
        end
        else if (cnt_reg != '0)
        begin
            // top quotient bit set means quotient at least 2^(QUOT_W-1)
            if (ge)
            begin
                r_reg <= r_reg - dsh_reg[fwtbh_pkg::PROD_W-1:0];
            end
            q_reg   <= {q_reg[fwtbh_pkg::QUOT_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.quot = q_reg;

endmodule

// ===== hdl/flywheel_tbh_velocity_controller_unit.sv =====
// flow: a sample word computes rpm (skipped when its elapsed time is zero), then the error, drive
// update and crossing check; a set-target word goes straight to power scaling, which zero max power skips
// handshake: one word at a time; the next word is accepted the cycle after the result enters the
// output register; the multiplier takes two bits of b and the divider one quotient bit per cycle;
// a result that is not taken holds the block
// reset: all state clears, registers return to 900 / 1678 / 210 / 12000, first-crossing armed
module flywheel_tbh_velocity_controller_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    fwtbh_item_if.sink           item,
    fwtbh_result_if.source       result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [fwtbh_pkg::CFG_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RPM_MUL,
        S_RPM_DIV,
        S_ERR,
        S_ERR_MUL,
        S_CROSS,
        S_POW,
        S_POW_MUL,
        S_MV,
        S_MV_MUL,
        S_MV_DIV,
        S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] cpr_reg;
    logic [15:0] gain_reg;
    logic [7:0]  maxp_reg;
    logic [13:0] fsmv_reg;

    // controller state
    logic [31:0] last_pos_reg;
    logic [31:0] last_time_reg;
    logic [fwtbh_pkg::RPM_W-1:0]   velocity_reg;
    logic [fwtbh_pkg::TGT_W-1:0]   target_reg;
    logic [fwtbh_pkg::DRIVE_W-1:0] drive_reg;
    logic [fwtbh_pkg::DRIVE_W-1:0] taken_back_reg;
    logic [fwtbh_pkg::DRIVE_W-1:0] guess_reg;
    logic [fwtbh_pkg::ERR_W-1:0]   prev_err_reg;
    logic                          awaiting_reg;

    // working registers
    logic                          delta_neg_reg;
    logic [fwtbh_pkg::ERR_W-1:0]   err_reg;
    logic                          crossed_reg;
    logic [7:0]                    power_reg;
    logic [13:0]                   mv_reg;

    // output word
    logic                          rvalid_reg;
    logic [7:0]                    r_power_reg;
    logic [13:0]                   r_mv_reg;
    logic [fwtbh_pkg::RPM_W-1:0]   r_rpm_reg;
    logic [fwtbh_pkg::DRIVE_W-1:0] r_drive_reg;
    logic                          r_crossed_reg;

    fwtbh_pkg::mul_req_t mul0_req;
    fwtbh_pkg::mul_req_t mul1_req;
    fwtbh_pkg::mul_rsp_t mul0_rsp;
    fwtbh_pkg::mul_rsp_t mul1_rsp;
    fwtbh_pkg::div_req_t div_req;
    fwtbh_pkg::div_rsp_t div_rsp;

    logic                           accept;
    logic [31:0]                    elapsed;
    logic [32:0]                    delta;
    logic [32:0]                    delta_mag;
    logic [15:0]                    cpr_eff;
    logic [fwtbh_pkg::ERR_W-1:0]    vel_ext;
    logic [fwtbh_pkg::ERR_W-1:0]    err_now;
    logic [fwtbh_pkg::ERR_W-1:0]    err_mag;
    logic [fwtbh_pkg::ERR_W-1:0]    prime_err;
    logic [fwtbh_pkg::DRIVE_W-1:0]  guess_sat;
    logic [fwtbh_pkg::RPM_W-1:0]    rpm_sat;
    logic [30:0]                    prod_s;
    logic [30:0]                    sum;
    logic [24:0]                    sum_clip;
    logic [24:0]                    sum_round;
    logic [fwtbh_pkg::DRIVE_W:0]    avg_sum;
    logic [25:0]                    pw_round;
    logic [9:0]                     pw;
    logic                           load_out;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        elapsed   = item.timestamp_ms - last_time_reg;
        delta     = {item.encoder_position[31], item.encoder_position}
                  - {last_pos_reg[31], last_pos_reg};
        delta_mag = delta[32] ? (33'd0 - delta) : delta;
        cpr_eff   = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;

        vel_ext   = {velocity_reg[fwtbh_pkg::RPM_W-1], velocity_reg};
        err_now   = {4'b0000, target_reg} - vel_ext;
        err_mag   = err_now[fwtbh_pkg::ERR_W-1] ? (14'd0 - err_now) : err_now;
        prime_err = {4'b0000, item.target_rpm} - vel_ext;
        guess_sat = (item.open_loop_drive > fwtbh_pkg::DRIVE_ONE)
                  ? fwtbh_pkg::DRIVE_ONE : item.open_loop_drive;

        // saturate the magnitude quotient to the signed rpm range
        if (!delta_neg_reg)
        begin
            rpm_sat = (div_rsp.quot > 14'd4095) ? fwtbh_pkg::RPM_MAX
                                                : div_rsp.quot[fwtbh_pkg::RPM_W-1:0];
        end
        else
        begin
            rpm_sat = (div_rsp.quot > 14'd4096) ? fwtbh_pkg::RPM_MIN
                                                : (13'd0 - div_rsp.quot[fwtbh_pkg::RPM_W-1:0]);
        end

        // Q1.24 integration, clipped to [0, 1], rounded back to Q1.16
        prod_s = {2'b00, mul0_rsp.prod[28:0]};
        sum    = {6'b000000, drive_reg, 8'h00}
               + (err_reg[fwtbh_pkg::ERR_W-1] ? (31'd0 - prod_s) : prod_s);
        if (sum[30])
        begin
            sum_clip = '0;
        end
        else if (sum[29:0] > fwtbh_pkg::SUM_ONE)
        begin
            sum_clip = fwtbh_pkg::SUM_ONE[24:0];
        end
        else
        begin
            sum_clip = sum[24:0];
        end
        sum_round = sum_clip + 25'd128;

        avg_sum  = {1'b0, drive_reg} + {1'b0, taken_back_reg} + 18'd1;

        pw_round = mul0_rsp.prod[25:0] + 26'd32768;
        pw       = pw_round[25:16];

        load_out = (state_reg == S_EMIT) && (!rvalid_reg || result.ready);
    end

    // operand routing to the serial units; mul0 and the divider are shared between steps
    always_comb
    begin
        mul0_req = '0;
        mul1_req = '0;
        div_req  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.func == fwtbh_pkg::FUNC_SAMPLE && elapsed != 32'd0)
                begin
                    mul0_req.start  = 1'b1;
                    mul0_req.a      = delta_mag;
                    mul0_req.b      = fwtbh_pkg::RPM_SCALE;
                    mul0_req.digits = fwtbh_pkg::DIGITS_FULL;
                    mul1_req.start  = 1'b1;
                    mul1_req.a      = {1'b0, elapsed};
                    mul1_req.b      = cpr_eff;
                    mul1_req.digits = fwtbh_pkg::DIGITS_FULL;
                end
            end
            S_RPM_MUL:
            begin
                if (!mul0_rsp.busy && !mul1_rsp.busy)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul0_rsp.prod;
                    div_req.den   = mul1_rsp.prod[fwtbh_pkg::DEN_W-1:0];
                end
            end
            S_ERR:
            begin
                mul0_req.start  = 1'b1;
                mul0_req.a      = {19'd0, err_mag};
                mul0_req.b      = gain_reg;
                mul0_req.digits = fwtbh_pkg::DIGITS_FULL;
            end
            S_POW:
            begin
                if (maxp_reg != 8'd0)
                begin
                    mul0_req.start  = 1'b1;
                    mul0_req.a      = {16'd0, drive_reg};
                    mul0_req.b      = {maxp_reg, 8'h00};
                    mul0_req.digits = fwtbh_pkg::DIGITS_HALF;
                end
            end
            S_MV:
            begin
                mul0_req.start  = 1'b1;
                mul0_req.a      = {19'd0, fsmv_reg};
                mul0_req.b      = {power_reg, 8'h00};
                mul0_req.digits = fwtbh_pkg::DIGITS_HALF;
            end
            S_MV_MUL:
            begin
                if (!mul0_rsp.busy)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul0_rsp.prod;
                    div_req.den   = {40'd0, maxp_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    fwtbh_mul u_mul0 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul0_req),
        .rsp   (mul0_rsp)
    );

    fwtbh_mul u_mul1 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul1_req),
        .rsp   (mul1_rsp)
    );

    fwtbh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= 16'd900;
            gain_reg <= 16'd1678;
            maxp_reg <= 8'd210;
            fsmv_reg <= 14'd12000;
        end
        else if (cfg_we)
        begin
            unique case (fwtbh_pkg::cfg_idx_t'(cfg_index))
                fwtbh_pkg::CFG_COUNTS_PER_REV: cpr_reg  <= cfg_data;
                fwtbh_pkg::CFG_LOOP_GAIN:      gain_reg <= cfg_data;
                fwtbh_pkg::CFG_MAX_POWER:      maxp_reg <= cfg_data[7:0];
                fwtbh_pkg::CFG_FULL_SCALE_MV:  fsmv_reg <= cfg_data[13:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_pos_reg   <= '0;
            last_time_reg  <= '0;
            velocity_reg   <= '0;
            target_reg     <= '0;
            drive_reg      <= '0;
            taken_back_reg <= '0;
            guess_reg      <= '0;
            prev_err_reg   <= '0;
            awaiting_reg   <= 1'b1;
            delta_neg_reg  <= 1'b0;
            err_reg        <= '0;
            crossed_reg    <= 1'b0;
            power_reg      <= '0;
            mv_reg         <= '0;
            rvalid_reg     <= 1'b0;
            r_power_reg    <= '0;
            r_mv_reg       <= '0;
            r_rpm_reg      <= '0;
            r_drive_reg    <= '0;
            r_crossed_reg  <= 1'b0;
        end
        else
        begin
            if (result.ready && !load_out)
            begin
                rvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.func == fwtbh_pkg::FUNC_SET_TARGET)
                        begin
                            target_reg     <= item.target_rpm;
                            prev_err_reg   <= prime_err;
                            guess_reg      <= guess_sat;
                            awaiting_reg   <= 1'b1;
                            taken_back_reg <= '0;
                            crossed_reg    <= 1'b0;
                            state_reg      <= S_POW;
                        end
                        else
                        begin
                            last_pos_reg  <= item.encoder_position;
                            last_time_reg <= item.timestamp_ms;
                            delta_neg_reg <= delta[32];
                            crossed_reg   <= 1'b0;
                            // no time elapsed: keep the old velocity
                            state_reg     <= (elapsed != 32'd0) ? S_RPM_MUL : S_ERR;
                        end
                    end
                end
                S_RPM_MUL:
                begin
                    if (!mul0_rsp.busy && !mul1_rsp.busy)
                    begin
                        state_reg <= S_RPM_DIV;
                    end
                end
                S_RPM_DIV:
                begin
                    if (!div_rsp.busy)
                    begin
                        velocity_reg <= rpm_sat;
                        state_reg    <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_now;
                    state_reg <= S_ERR_MUL;
                end
                S_ERR_MUL:
                begin
                    if (!mul0_rsp.busy)
                    begin
                        drive_reg <= sum_round[24:8];
                        state_reg <= S_CROSS;
                    end
                end
                S_CROSS:
                begin
                    // zero counts as non-negative
                    if (err_reg[fwtbh_pkg::ERR_W-1] != prev_err_reg[fwtbh_pkg::ERR_W-1])
                    begin
                        crossed_reg <= 1'b1;
                        if (awaiting_reg)
                        begin
                            drive_reg      <= guess_reg;
                            taken_back_reg <= guess_reg;
                            awaiting_reg   <= 1'b0;
                        end
                        else
                        begin
                            drive_reg      <= avg_sum[fwtbh_pkg::DRIVE_W:1];
                            taken_back_reg <= avg_sum[fwtbh_pkg::DRIVE_W:1];
                        end
                    end
                    prev_err_reg <= err_reg;
                    state_reg    <= S_POW;
                end
                S_POW:
                begin
                    if (maxp_reg == 8'd0)
                    begin
                        power_reg <= '0;
                        mv_reg    <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_POW_MUL;
                    end
                end
                S_POW_MUL:
                begin
                    if (!mul0_rsp.busy)
                    begin
                        power_reg <= (pw > {2'b00, maxp_reg}) ? maxp_reg : pw[7:0];
                        state_reg <= S_MV;
                    end
                end
                S_MV:
                begin
                    state_reg <= S_MV_MUL;
                end
                S_MV_MUL:
                begin
                    if (!mul0_rsp.busy)
                    begin
                        state_reg <= S_MV_DIV;
                    end
                end
                S_MV_DIV:
                begin
                    if (!div_rsp.busy)
                    begin
                        mv_reg    <= div_rsp.quot;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (load_out)
                    begin
                        rvalid_reg    <= 1'b1;
                        r_power_reg   <= power_reg;
                        r_mv_reg      <= mv_reg;
                        r_rpm_reg     <= velocity_reg;
                        r_drive_reg   <= drive_reg;
                        r_crossed_reg <= crossed_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = rvalid_reg;
    assign result.motor_power  = r_power_reg;
    assign result.voltage_mv   = r_mv_reg;
    assign result.measured_rpm = r_rpm_reg;
    assign result.drive_level  = r_drive_reg;
    assign result.crossed      = r_crossed_reg;

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mul0_rsp.busy && !mul1_rsp.busy && !div_rsp.busy)
        else $error("serial unit busy while waiting for a word");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while running");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive_reg <= fwtbh_pkg::DRIVE_ONE && taken_back_reg <= fwtbh_pkg::DRIVE_ONE)
        else $error("drive above one");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.func == fwtbh_pkg::FUNC_SET_TARGET |=> awaiting_reg && state_reg == S_POW)
        else $error("set target did not re-arm crossing detection");

    a_power_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> result.motor_power <= $past(maxp_reg))
        else $error("motor power above max power");

endmodule
